// ===== rtl/dcdq_pkg.sv =====
// Shared types and constants of the direction change dwell and delay qualifier.
`default_nettype none
package dcdq_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_LOW        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_HIGH       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_LOW       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_HIGH      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_SEED       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_STREAM_ID  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_STREAM_ID = 3'd6;

   localparam logic [31:0] STEP_MUL   = 32'h85EBCA6B;
   localparam logic [31:0] STREAM_MUL = 32'hC2B2AE35;
   localparam logic [31:0] MIX_MUL1   = 32'h7FEB352D;
   localparam logic [31:0] MIX_MUL2   = 32'h846CA68B;

   localparam logic [4:0]  ACTION_COUNT = 5'd18;
   localparam logic [3:0]  NO_PENDING   = 4'd15;
   localparam logic [15:0] HELD_LIMIT   = 16'd255;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic        start;
      logic [31:0] seed;
      logic [31:0] step;
      logic [31:0] stream;
      logic [7:0]  lo;
      logic [7:0]  hi;
   } draw_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } draw_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/dcdq_draw_unit.sv =====
// Iterative hash and bounded remainder unit that produces one pseudo-random draw.
`default_nettype none
module dcdq_draw_unit
   import dcdq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire draw_req_type draw_req,
   output draw_rsp_type      draw_rsp
);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_MIX1 = 3'd1;
   localparam logic [2:0] U_MIX2 = 3'd2;
   localparam logic [2:0] U_MIX3 = 3'd3;
   localparam logic [2:0] U_DIV  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        done_ff, done_in;
   logic [31:0] v_ff, v_in;
   logic [8:0]  rem_ff, rem_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] stream_ff, stream_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;
   logic [7:0]  value_ff, value_in;

   logic [31:0] mul_a, mul_b, product, mix_sum;
   logic [63:0] mul_wide;
   logic [8:0]  divisor, rem_a, rem_b;

   function automatic logic [8:0] div_step(input logic [8:0] r, input logic b,
                                           input logic [8:0] d);
      logic [9:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[8:0];
   endfunction

   always_comb begin
      unique case (state_ff)
         U_IDLE: begin
            mul_a = draw_req.step;
            mul_b = STEP_MUL;
         end
         U_MIX1: begin
            mul_a = stream_ff;
            mul_b = STREAM_MUL;
         end
         U_MIX2: begin
            mul_a = v_ff;
            mul_b = MIX_MUL1;
         end
         default: begin
            mul_a = v_ff;
            mul_b = MIX_MUL2;
         end
      endcase
      mul_wide = mul_a * mul_b;
      product  = mul_wide[31:0];
      mix_sum  = v_ff + product;
      divisor  = {1'b0, hi_ff} - {1'b0, lo_ff} + 9'd1;
      rem_a    = div_step(rem_ff, v_ff[31], divisor);
      rem_b    = div_step(rem_a, v_ff[30], divisor);
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      v_in      = v_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      stream_in = stream_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      value_in  = value_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (draw_req.start) begin
               v_in      = draw_req.seed + product;
               stream_in = draw_req.stream;
               lo_in     = draw_req.lo;
               hi_in     = draw_req.hi;
               state_in  = U_MIX1;
            end
         end
         U_MIX1: begin
            v_in     = mix_sum ^ (mix_sum >> 16);
            state_in = U_MIX2;
         end
         U_MIX2: begin
            v_in     = product ^ (product >> 15);
            state_in = U_MIX3;
         end
         U_MIX3: begin
            v_in     = product ^ (product >> 16);
            rem_in   = 9'd0;
            count_in = 4'd0;
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in   = rem_b;
            v_in     = {v_ff[29:0], 2'b00};
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
               if (hi_ff > lo_ff) begin
                  value_in = lo_ff + rem_b[7:0];
               end else if (hi_ff == lo_ff) begin
                  value_in = lo_ff;
               end else begin
                  value_in = 8'd0;
               end
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      rem_ff    <= rem_in;
      count_ff  <= count_in;
      stream_ff <= stream_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      value_ff  <= value_in;
   end

   assign draw_rsp.done  = done_ff;
   assign draw_rsp.value = value_ff;

endmodule
`default_nettype wire

// ===== rtl/direction_change_dwell_delay_qualifier.sv =====
// Top level of the direction change dwell and delay qualifier.
// Each step word leads to a result in the output register. The two draws run one after
// the other through a single shared unit. Each draw hashes with the 32 by 32 multiplier
// and then runs the two-bit-per-cycle remainder loop. The finish state then updates the
// state and loads the result. That state waits while the output register still holds a
// result that has not been accepted. A clear word produces no result. The input side is
// ready only while no step is in progress. The result register lets the next word enter
// while a result waits.
`default_nettype none
module direction_change_dwell_delay_qualifier
   import dcdq_pkg::*;
#(
   parameter logic [15:0] HELD_MAX = HELD_LIMIT
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // wanted_action[4:0], previous_action[9:5], held_steps[17:10], zero pad
   input  wire logic [23:0]                req_tdata,
   // operation
   input  wire logic                       req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // executed_action[4:0], next_held_steps[12:5], zero pad
   output logic [15:0]                     rsp_tdata,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam logic [1:0] T_IDLE   = 2'd0;
   localparam logic [1:0] T_HOLD   = 2'd1;
   localparam logic [1:0] T_DELAY  = 2'd2;
   localparam logic [1:0] T_FINISH = 2'd3;

   logic [7:0]  hold_low_ff, hold_high_ff, delay_low_ff, delay_high_ff;
   logic [31:0] hash_seed_ff, hold_stream_id_ff, delay_stream_id_ff;

   logic [1:0]  state_ff, state_in;
   logic [31:0] step_count_ff, step_count_in;
   logic [7:0]  hold_need_ff, hold_need_in;
   logic [3:0]  pending_ff, pending_in;
   logic [7:0]  delay_left_ff, delay_left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic [4:0]  want_ff, want_in;
   logic [4:0]  prev_ff, prev_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  hold_pick_ff, hold_pick_in;
   logic [7:0]  delay_pick_ff, delay_pick_in;

   draw_req_type draw_req;
   draw_rsp_type draw_rsp;

   logic        req_accept, out_free;
   logic [4:0]  want_c, prev_c;
   logic [3:0]  wish_dir, cur_dir, exec_dir;
   logic        diff, go;
   logic [7:0]  delay_eff, next_held;

   dcdq_draw_unit u_draw (
      .clock    (clock),
      .reset    (reset),
      .draw_req (draw_req),
      .draw_rsp (draw_rsp)
   );

   assign req_tready = (state_ff == T_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      draw_req.start  = (req_accept && (req_tuser == OP_STEP))
                        || ((state_ff == T_HOLD) && draw_rsp.done);
      draw_req.seed   = hash_seed_ff;
      draw_req.step   = step_count_ff;
      draw_req.stream = (state_ff == T_IDLE) ? hold_stream_id_ff : delay_stream_id_ff;
      draw_req.lo     = (state_ff == T_IDLE) ? hold_low_ff : delay_low_ff;
      draw_req.hi     = (state_ff == T_IDLE) ? hold_high_ff : delay_high_ff;
   end

   always_comb begin
      want_c    = (want_ff >= ACTION_COUNT) ? 5'd0 : want_ff;
      prev_c    = (prev_ff >= ACTION_COUNT) ? 5'd0 : prev_ff;
      wish_dir  = want_c[4:1];
      cur_dir   = prev_c[4:1];
      diff      = (wish_dir != cur_dir);
      delay_eff = (diff && (wish_dir != pending_ff)) ? delay_pick_ff : delay_left_ff;
      go        = diff && (delay_eff == 8'd0) && (held_ff >= hold_need_ff);
      exec_dir  = go ? wish_dir : cur_dir;
      if (go) begin
         next_held = 8'd1;
      end else if ({8'd0, held_ff} >= HELD_MAX) begin
         next_held = HELD_MAX[7:0];
      end else begin
         next_held = held_ff + 8'd1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_count_in = step_count_ff;
      hold_need_in  = hold_need_ff;
      pending_in    = pending_ff;
      delay_left_in = delay_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      want_in       = want_ff;
      prev_in       = prev_ff;
      held_in       = held_ff;
      hold_pick_in  = hold_pick_ff;
      delay_pick_in = delay_pick_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               if (req_tuser == OP_CLEAR) begin
                  hold_need_in  = 8'd0;
                  pending_in    = NO_PENDING;
                  delay_left_in = 8'd0;
               end else begin
                  want_in  = req_tdata[4:0];
                  prev_in  = req_tdata[9:5];
                  held_in  = req_tdata[17:10];
                  state_in = T_HOLD;
               end
            end
         end
         T_HOLD: begin
            if (draw_rsp.done) begin
               hold_pick_in = draw_rsp.value;
               state_in     = T_DELAY;
            end
         end
         T_DELAY: begin
            if (draw_rsp.done) begin
               delay_pick_in = draw_rsp.value;
               state_in      = T_FINISH;
            end
         end
         T_FINISH: begin
            if (out_free) begin
               step_count_in = step_count_ff + 32'd1;
               if (go) begin
                  hold_need_in = hold_pick_ff;
                  pending_in   = NO_PENDING;
               end else begin
                  pending_in = diff ? wish_dir : NO_PENDING;
               end
               delay_left_in = (diff && !go && (delay_eff != 8'd0))
                               ? delay_eff - 8'd1 : delay_eff;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {3'b000, next_held, exec_dir, want_c[0]};
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= T_IDLE;
         step_count_ff      <= 32'd0;
         hold_need_ff       <= 8'd0;
         pending_ff         <= NO_PENDING;
         delay_left_ff      <= 8'd0;
         rsp_valid_ff       <= 1'b0;
         hold_low_ff        <= 8'd0;
         hold_high_ff       <= 8'd0;
         delay_low_ff       <= 8'd0;
         delay_high_ff      <= 8'd0;
         hash_seed_ff       <= 32'd0;
         hold_stream_id_ff  <= 32'd0;
         delay_stream_id_ff <= 32'd1;
      end else begin
         state_ff      <= state_in;
         step_count_ff <= step_count_in;
         hold_need_ff  <= hold_need_in;
         pending_ff    <= pending_in;
         delay_left_ff <= delay_left_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HOLD_LOW:        hold_low_ff        <= csr_wdata[7:0];
               CSR_HOLD_HIGH:       hold_high_ff       <= csr_wdata[7:0];
               CSR_DELAY_LOW:       delay_low_ff       <= csr_wdata[7:0];
               CSR_DELAY_HIGH:      delay_high_ff      <= csr_wdata[7:0];
               CSR_HASH_SEED:       hash_seed_ff       <= csr_wdata;
               CSR_HOLD_STREAM_ID:  hold_stream_id_ff  <= csr_wdata;
               CSR_DELAY_STREAM_ID: delay_stream_id_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      want_ff       <= want_in;
      prev_ff       <= prev_in;
      held_ff       <= held_in;
      hold_pick_ff  <= hold_pick_in;
      delay_pick_ff <= delay_pick_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/dcdq_checker.sv =====
// Port-level checker of the direction change dwell and delay qualifier and its bind.
`default_nettype none
module dcdq_checker
   import dcdq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed or dropped");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] < ACTION_COUNT))
      else $error("executed action out of range");

   a_held_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:5] != 8'd0))
      else $error("next held count is zero");

   a_busy_after_step: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_STEP)) |=> !req_tready)
      else $error("input ready right after a step word");

endmodule

bind direction_change_dwell_delay_qualifier dcdq_checker u_checker (.*);
`default_nettype wire
